// ===== rtl/core/tpr_pkg.sv =====
// Shared widths, constants and register indexes for the PID remap / CC restamp block.
package tpr_pkg;

    localparam int PID_W     = 13;
    localparam int CC_W      = 4;
    localparam int PID_COUNT = 1 << PID_W;
    localparam int TDATA_W   = ((PID_W + CC_W + 7) / 8) * 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [PID_W-1:0] NULL_PID = '1;
    localparam logic [PID_W-1:0] PID_PAT  = '0;

    localparam logic [CFG_IDX_W-1:0] REG_VIDEO_FROM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIDEO_TO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO_FROM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO_TO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PMT_FROM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PMT_TO     = 3'd5;

    typedef struct packed {
        logic            seen;
        logic [CC_W-1:0] cc;
    } cc_entry_t;

    function automatic logic pair_hits(
        input logic [PID_W-1:0] pid,
        input logic [PID_W-1:0] from_pid,
        input logic [PID_W-1:0] to_pid
    );
        return (from_pid != NULL_PID) && (to_pid != NULL_PID) && (pid == from_pid);
    endfunction

endpackage

// ===== rtl/core/ts_pid_remap_cc_restamp_top.sv =====
// Transport stream PID remapper with per-PID continuity counter restamping.
//
// Input channel s_*: one packet header per item; s_tdata carries pid_in and
// cc_in, s_tuser the payload flag. Output channel m_*: one result per item
// with the remapped PID, the counter to write and a restamp flag.
// The cfg channel writes the six pair registers and is always ready; it is
// to be used only while no item is in flight, a rule the block leaves to the user.
// The PID is remapped as the item is accepted and the remapped PID
// addresses a single 8192 x 5 bit memory ({seen, counter}). The read data
// is registered with the item into stage 1; the next counter is formed and
// written back as the result enters the output register. A back-to-back
// item on the same PID takes the written value from a forwarding register.
// Throughput: one item per cycle while the receiver keeps taking results;
// a new item is accepted as the item in stage 1 moves to the output register.
// After reset the memory is cleared one entry per cycle: s_tready stays
// low until every entry is cleared. Pair registers reset to the null PID.
// When the receiver stalls, the output register holds, then stage 1
// holds, then s_tready drops; no item is lost.
module ts_pid_remap_cc_restamp_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tpr_pkg::TDATA_W-1:0]   s_tdata,   // pid_in[12:0], cc_in[16:13], zero pad
    input  logic                          s_tuser,   // has_payload
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tpr_pkg::TDATA_W-1:0]   m_tdata,   // pid_out[12:0], cc_out[16:13], zero pad
    output logic                          m_tuser,   // cc_restamped
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpr_pkg::PID_W-1:0]     cfg_data
);

    localparam int PW = tpr_pkg::PID_W;
    localparam int CW = tpr_pkg::CC_W;

    // configuration registers
    logic [PW-1:0] video_from_reg, video_to_reg;
    logic [PW-1:0] audio_from_reg, audio_to_reg;
    logic [PW-1:0] pmt_from_reg, pmt_to_reg;

    // counter memory and clearing pass
    tpr_pkg::cc_entry_t cc_mem [tpr_pkg::PID_COUNT];
    logic               clearing_reg;
    logic [PW-1:0]      clr_idx_reg;

    // stage 1
    logic               s1_valid_reg;
    logic [PW-1:0]      s1_pid_reg;
    logic               s1_payload_reg;
    logic [CW-1:0]      s1_cc_reg;
    tpr_pkg::cc_entry_t s1_rdata_reg;
    logic               s1_fwd_reg;
    tpr_pkg::cc_entry_t s1_fwd_val_reg;

    // output register
    logic               out_valid_reg;
    logic [PW-1:0]      out_pid_reg;
    logic [CW-1:0]      out_cc_reg;
    logic               out_restamp_reg;

    logic               in_fire;
    logic               s1_go;
    logic [PW-1:0]      pid_in;
    logic [PW-1:0]      pid_next;
    tpr_pkg::cc_entry_t s1_entry;
    logic [CW-1:0]      s1_cc_next;
    tpr_pkg::cc_entry_t s1_wr_entry;
    logic               mem_we;
    logic [PW-1:0]      mem_waddr;
    tpr_pkg::cc_entry_t mem_wdata;

    assign cfg_ready = 1'b1;

    assign s1_go    = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clearing_reg && (!s1_valid_reg || s1_go);
    assign in_fire  = s_tvalid && s_tready;
    assign pid_in   = s_tdata[PW-1:0];

    always_comb begin
        priority if (tpr_pkg::pair_hits(pid_in, pmt_from_reg, pmt_to_reg)) begin
            pid_next = pmt_to_reg;
        end else if (pid_in == tpr_pkg::PID_PAT) begin
            pid_next = tpr_pkg::PID_PAT;
        end else if (tpr_pkg::pair_hits(pid_in, audio_from_reg, audio_to_reg)) begin
            pid_next = audio_to_reg;
        end else if (tpr_pkg::pair_hits(pid_in, video_from_reg, video_to_reg)) begin
            pid_next = video_to_reg;
        end else begin
            pid_next = pid_in;
        end
    end

    always_comb begin
        s1_entry         = s1_fwd_reg ? s1_fwd_val_reg : s1_rdata_reg;
        s1_cc_next       = s1_entry.seen ? s1_entry.cc + CW'(1) : '0;
        s1_wr_entry.seen = 1'b1;
        s1_wr_entry.cc   = s1_cc_next;
    end

    always_comb begin
        if (clearing_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = s1_go && s1_payload_reg;
            mem_waddr = s1_pid_reg;
            mem_wdata = s1_wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cc_mem[mem_waddr] <= mem_wdata;
        end
        if (in_fire) begin
            s1_rdata_reg <= cc_mem[pid_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clearing_reg) begin
            clr_idx_reg <= clr_idx_reg + PW'(1);
            if (clr_idx_reg == '1) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            video_from_reg <= tpr_pkg::NULL_PID;
            video_to_reg   <= tpr_pkg::NULL_PID;
            audio_from_reg <= tpr_pkg::NULL_PID;
            audio_to_reg   <= tpr_pkg::NULL_PID;
            pmt_from_reg   <= tpr_pkg::NULL_PID;
            pmt_to_reg     <= tpr_pkg::NULL_PID;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tpr_pkg::REG_VIDEO_FROM: video_from_reg <= cfg_data;
                tpr_pkg::REG_VIDEO_TO:   video_to_reg   <= cfg_data;
                tpr_pkg::REG_AUDIO_FROM: audio_from_reg <= cfg_data;
                tpr_pkg::REG_AUDIO_TO:   audio_to_reg   <= cfg_data;
                tpr_pkg::REG_PMT_FROM:   pmt_from_reg   <= cfg_data;
                tpr_pkg::REG_PMT_TO:     pmt_to_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // stage 1 payload; forward a same-PID write that lands on the read edge
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_pid_reg     <= pid_next;
            s1_payload_reg <= s_tuser;
            s1_cc_reg      <= s_tdata[PW+CW-1:PW];
            s1_fwd_reg     <= s1_go && s1_payload_reg && (s1_pid_reg == pid_next);
            s1_fwd_val_reg <= s1_wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_go) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            out_pid_reg     <= s1_pid_reg;
            out_cc_reg      <= s1_payload_reg ? s1_cc_next : s1_cc_reg;
            out_restamp_reg <= s1_payload_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(tpr_pkg::TDATA_W - PW - CW)'(0), out_cc_reg, out_pid_reg};
    assign m_tuser  = out_restamp_reg;

endmodule

// ===== verif/ts_pid_remap_cc_restamp_top_tb.sv =====
// Self-checking testbench for the PID remap / continuity counter restamp block.
module ts_pid_remap_cc_restamp_top_tb;

    localparam int CFG_REGS     = 6;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 112;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int TAIL_CYCLES  = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 300;

    localparam logic [tpr_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [tpr_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                     kind;
        logic [tpr_pkg::CFG_IDX_W-1:0] idx;
        logic [tpr_pkg::PID_W-1:0]     pid;     // register data on a ROW_CFG row
        logic                          payload;
        logic [tpr_pkg::CC_W-1:0]      cc;
        logic                          known;
        logic [tpr_pkg::PID_W-1:0]     exp_pid;
        logic [tpr_pkg::CC_W-1:0]      exp_cc;
        logic                          exp_rs;
    } dir_row_t;

    typedef struct packed {
        logic [tpr_pkg::PID_W-1:0] pid;
        logic [tpr_pkg::CC_W-1:0]  cc;
        logic                      restamped;
    } hdr_result_t;

    localparam int DIR_ROWS_N = 28;
    localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
        '{ROW_ITEM, '0, 13'h0000, 1'b1, 4'h5, 1'b1, 13'h0000, 4'h0, 1'b1},
        '{ROW_ITEM, '0, 13'h0000, 1'b1, 4'h5, 1'b1, 13'h0000, 4'h1, 1'b1},
        '{ROW_ITEM, '0, 13'h1FFF, 1'b0, 4'hF, 1'b1, 13'h1FFF, 4'hF, 1'b0},
        '{ROW_ITEM, '0, 13'h1FFF, 1'b1, 4'h0, 1'b1, 13'h1FFF, 4'h0, 1'b1},
        '{ROW_ITEM, '0, 13'h1FFF, 1'b1, 4'hF, 1'b1, 13'h1FFF, 4'h1, 1'b1},
        '{ROW_ITEM, '0, 13'h0ABC, 1'b0, 4'h0, 1'b1, 13'h0ABC, 4'h0, 1'b0},
        '{ROW_CFG, tpr_pkg::REG_VIDEO_FROM, 13'h0100, 1'b0, 4'h0, 1'b0, '0, '0, 1'b0},
        '{ROW_CFG, tpr_pkg::REG_VIDEO_TO,   13'h0200, 1'b0, 4'h0, 1'b0, '0, '0, 1'b0},
        '{ROW_ITEM, '0, 13'h0100, 1'b1, 4'h7, 1'b0, '0, '0, 1'b0},
        '{ROW_ITEM, '0, 13'h0200, 1'b1, 4'h3, 1'b0, '0, '0, 1'b0},
        // same from PID on audio: audio wins over video
        '{ROW_CFG, tpr_pkg::REG_AUDIO_FROM, 13'h0100, 1'b0, 4'h0, 1'b0, '0, '0, 1'b0},
        '{ROW_CFG, tpr_pkg::REG_AUDIO_TO,   13'h0300, 1'b0, 4'h0, 1'b0, '0, '0, 1'b0},
        '{ROW_ITEM, '0, 13'h0100, 1'b1, 4'h2, 1'b0, '0, '0, 1'b0},
        // PMT pair moves the PAT PID
        '{ROW_CFG, tpr_pkg::REG_PMT_FROM,   13'h0000, 1'b0, 4'h0, 1'b0, '0, '0, 1'b0},
        '{ROW_CFG, tpr_pkg::REG_PMT_TO,     13'h0400, 1'b0, 4'h0, 1'b0, '0, '0, 1'b0},
        '{ROW_ITEM, '0, 13'h0000, 1'b1, 4'h0, 1'b0, '0, '0, 1'b0},
        // null on the to side disables
        '{ROW_CFG, tpr_pkg::REG_PMT_TO,     13'h1FFF, 1'b0, 4'h0, 1'b0, '0, '0, 1'b0},
        '{ROW_ITEM, '0, 13'h0000, 1'b1, 4'h0, 1'b0, '0, '0, 1'b0},
        // null on the from side disables
        '{ROW_CFG, tpr_pkg::REG_PMT_FROM,   13'h1FFF, 1'b0, 4'h0, 1'b0, '0, '0, 1'b0},
        '{ROW_CFG, tpr_pkg::REG_PMT_TO,     13'h0500, 1'b0, 4'h0, 1'b0, '0, '0, 1'b0},
        '{ROW_ITEM, '0, 13'h0100, 1'b1, 4'h0, 1'b0, '0, '0, 1'b0},
        // PAT identity beats the video pair
        '{ROW_CFG, tpr_pkg::REG_VIDEO_FROM, 13'h0000, 1'b0, 4'h0, 1'b0, '0, '0, 1'b0},
        '{ROW_CFG, tpr_pkg::REG_VIDEO_TO,   13'h0600, 1'b0, 4'h0, 1'b0, '0, '0, 1'b0},
        '{ROW_ITEM, '0, 13'h0000, 1'b0, 4'h9, 1'b0, '0, '0, 1'b0},
        // out-of-range indexes are ignored
        '{ROW_CFG, REG_SPARE_A,             13'h0000, 1'b0, 4'h0, 1'b0, '0, '0, 1'b0},
        '{ROW_CFG, REG_SPARE_B,             13'h1FFF, 1'b0, 4'h0, 1'b0, '0, '0, 1'b0},
        '{ROW_ITEM, '0, 13'h0100, 1'b1, 4'h0, 1'b0, '0, '0, 1'b0},
        '{ROW_ITEM, '0, 13'h0300, 1'b1, 4'h0, 1'b0, '0, '0, 1'b0}
    };

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [tpr_pkg::TDATA_W-1:0]   s_tdata   = '0;
    logic                          s_tuser   = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [tpr_pkg::TDATA_W-1:0]   m_tdata;
    logic                          m_tuser;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [tpr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tpr_pkg::PID_W-1:0]     cfg_data  = '0;

    logic [tpr_pkg::PID_W-1:0] pair_regs [CFG_REGS];
    logic [tpr_pkg::CC_W-1:0]  cc_table  [tpr_pkg::PID_COUNT];
    bit                        cc_seen   [tpr_pkg::PID_COUNT];
    logic [tpr_pkg::PID_W-1:0] pid_pool  [8];

    hdr_result_t expected_hdrs [$];
    int          errors       = 0;
    int          results_seen = 0;
    int          cycles       = 0;

    ts_pid_remap_cc_restamp_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit pair_live(input logic [tpr_pkg::PID_W-1:0] pid,
                                     input logic [tpr_pkg::PID_W-1:0] from_pid,
                                     input logic [tpr_pkg::PID_W-1:0] to_pid);
        return from_pid != tpr_pkg::NULL_PID && to_pid != tpr_pkg::NULL_PID &&
               pid == from_pid;
    endfunction

    function automatic logic [tpr_pkg::PID_W-1:0] remap_lookup(
        input logic [tpr_pkg::PID_W-1:0] pid);
        if (pair_live(pid, pair_regs[tpr_pkg::REG_PMT_FROM], pair_regs[tpr_pkg::REG_PMT_TO]))
            return pair_regs[tpr_pkg::REG_PMT_TO];
        if (pid == tpr_pkg::PID_PAT)
            return tpr_pkg::PID_PAT;
        if (pair_live(pid, pair_regs[tpr_pkg::REG_AUDIO_FROM],
                      pair_regs[tpr_pkg::REG_AUDIO_TO]))
            return pair_regs[tpr_pkg::REG_AUDIO_TO];
        if (pair_live(pid, pair_regs[tpr_pkg::REG_VIDEO_FROM],
                      pair_regs[tpr_pkg::REG_VIDEO_TO]))
            return pair_regs[tpr_pkg::REG_VIDEO_TO];
        return pid;
    endfunction

    function automatic hdr_result_t predict_header(input logic [tpr_pkg::PID_W-1:0] pid,
                                                   input logic payload,
                                                   input logic [tpr_pkg::CC_W-1:0] cc);
        hdr_result_t r;
        r.pid       = remap_lookup(pid);
        r.cc        = cc;
        r.restamped = 1'b0;
        if (payload) begin
            r.cc = cc_seen[r.pid] ? cc_table[r.pid] + tpr_pkg::CC_W'(1) : '0;
            cc_table[r.pid] = r.cc;
            cc_seen[r.pid]  = 1'b1;
            r.restamped     = 1'b1;
        end
        return r;
    endfunction

    task automatic send_header(input logic [tpr_pkg::PID_W-1:0] pid, input logic payload,
                               input logic [tpr_pkg::CC_W-1:0] cc, input bit known,
                               input hdr_result_t typed);
        hdr_result_t p;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(tpr_pkg::TDATA_W-tpr_pkg::PID_W-tpr_pkg::CC_W){1'b0}}, cc, pid};
        s_tuser  <= payload;
        do @(posedge aclk); while (!s_tready);
        p = predict_header(pid, payload, cc);
        expected_hdrs.push_back(known ? typed : p);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (expected_hdrs.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [tpr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tpr_pkg::PID_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < CFG_REGS)
            pair_regs[idx] = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [tpr_pkg::PID_W-1:0] pick_reg_pid();
        case ($urandom_range(0, 9))
            0:       return tpr_pkg::NULL_PID;
            1:       return tpr_pkg::PID_PAT;
            2:       return tpr_pkg::PID_W'($urandom);
            default: return pid_pool[$urandom_range(0, 7)];
        endcase
    endfunction

    function automatic logic [tpr_pkg::PID_W-1:0] pick_item_pid();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return pid_pool[$urandom_range(0, 7)];
        if (r < 8)
            return pair_regs[$urandom_range(0, CFG_REGS-1)];
        return tpr_pkg::PID_W'($urandom);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL ts_pid_remap_cc_restamp_top");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        hdr_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (expected_hdrs.size() == 0) begin
                $display("%0t: unexpected item pid %h cc %h restamped %b", $time,
                         m_tdata[tpr_pkg::PID_W-1:0], m_tdata[tpr_pkg::PID_W+:tpr_pkg::CC_W],
                         m_tuser);
                errors <= errors + 1;
            end else begin
                e = expected_hdrs.pop_front();
                if (m_tdata[tpr_pkg::PID_W-1:0] !== e.pid) begin
                    $display("%0t: pid_out expected %h got %h", $time, e.pid,
                             m_tdata[tpr_pkg::PID_W-1:0]);
                    errors <= errors + 1;
                end
                if (m_tdata[tpr_pkg::PID_W+:tpr_pkg::CC_W] !== e.cc) begin
                    $display("%0t: cc_out expected %h got %h", $time, e.cc,
                             m_tdata[tpr_pkg::PID_W+:tpr_pkg::CC_W]);
                    errors <= errors + 1;
                end
                if (m_tuser !== e.restamped) begin
                    $display("%0t: cc_restamped expected %b got %b", $time, e.restamped,
                             m_tuser);
                    errors <= errors + 1;
                end
            end
        end
    end

    // receiver stall pattern, plus one long hold while items are in flight
    initial begin
        int  mode;
        int  hold;
        int  tick;
        bit  held;
        mode = 0;
        hold = 0;
        tick = 0;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (tick % 50 == 0)
                mode = $urandom_range(0, 3);
            if (!held && results_seen >= HOLD_AFTER && s_tvalid && expected_hdrs.size() > 0) begin
                held = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (tick % 4 != 3);
                endcase
            end
        end
    end

    initial begin
        hdr_result_t typed;
        int          burst;
        for (int i = 0; i < CFG_REGS; i++)
            pair_regs[i] = tpr_pkg::NULL_PID;
        for (int i = 0; i < 8; i++)
            pid_pool[i] = tpr_pkg::PID_W'($urandom);
        pid_pool[0] = tpr_pkg::PID_PAT;
        pid_pool[1] = 13'h0001;
        pid_pool[2] = 13'h1FFE;
        pid_pool[3] = tpr_pkg::NULL_PID;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].kind == ROW_CFG) begin
                wait_drained();
                write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].pid);
            end else begin
                typed = '{DIR_ROWS[i].exp_pid, DIR_ROWS[i].exp_cc, DIR_ROWS[i].exp_rs};
                send_header(DIR_ROWS[i].pid, DIR_ROWS[i].payload, DIR_ROWS[i].cc,
                            DIR_ROWS[i].known, typed);
            end
        end

        typed = '0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            for (int r = 0; r < CFG_REGS; r++) begin
                if (ph == 0)
                    write_reg(tpr_pkg::CFG_IDX_W'(r), tpr_pkg::NULL_PID);
                else if (ph == NUM_PHASES - 1)
                    write_reg(tpr_pkg::CFG_IDX_W'(r), tpr_pkg::PID_PAT);
                else
                    write_reg(tpr_pkg::CFG_IDX_W'(r), pick_reg_pid());
            end
            if ($urandom_range(0, 1))
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          tpr_pkg::PID_W'($urandom));
            burst = $urandom_range(1, 24);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (burst == 0) begin
                    idle_cycles($urandom_range(1, 6));
                    burst = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
                end
                send_header(pick_item_pid(), ($urandom_range(0, 4) != 0),
                            tpr_pkg::CC_W'($urandom), 1'b0, typed);
                burst--;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("PASS ts_pid_remap_cc_restamp_top");
        else
            $display("FAIL ts_pid_remap_cc_restamp_top");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/tpr_pkg.sv
rtl/core/ts_pid_remap_cc_restamp_top.sv
verif/ts_pid_remap_cc_restamp_top_tb.sv
